// ===== design/fcd_pkg.sv =====
// fcd_pkg: shared types, constants and tables for the fibonacci cap direction unit
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
package fcd_pkg;

   // field and register widths
   localparam int INDEX_W = 12;
   localparam int COUNT_W = 13;
   localparam int CAP_W   = 16;
   localparam int DIR_W   = 16;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   // register indexes (address bit 2) and reset values
   localparam logic REG_RAY_COUNT = 1'b0;
   localparam logic REG_CAP_ANGLE = 1'b1;
   localparam logic [COUNT_W-1:0] RAY_COUNT_RESET = 13'd64;
   localparam logic [CAP_W-1:0]   CAP_ANGLE_RESET = 16'd23040;

   // degrees Q8.8 to Q0.32 turns: q = a*CAP_SCALE + floor((a*CAP_REM + CAP_OFFSET)/45)
   localparam logic [15:0] CAP_SCALE       = 16'd46603;
   localparam logic [4:0]  CAP_REM         = 5'd17;
   localparam logic [4:0]  CAP_OFFSET      = 5'd22;
   localparam logic [21:0] CAP_RECIP       = 22'd2982617;
   localparam int          CAP_RECIP_SHIFT = 27;

   // golden angle step, 0.381966 turn in Q0.32
   localparam logic [30:0] GOLDEN_STEP = 31'd1640531478;

   // cordic datapath
   localparam int CORDIC_STAGES = 16;
   localparam int XW            = 33;
   localparam int ZW            = 34;
   localparam int CORDIC_GAIN   = 652032874;

   // divider and root
   localparam int DIV_STAGES  = 32;
   localparam int DIVIDEND_W  = 45;
   localparam int SQRT_STAGES = 32;
   localparam int SQ_W        = 61;
   localparam int ROOT_W      = 63;

   localparam int QUEUE_DEPTH = 4;

   // one item between front and back
   typedef struct packed {
      logic [INDEX_W-1:0] ray_index;
      logic               oor;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // carried alongside the divider
   typedef struct packed {
      logic signed [XW-1:0] cp;
      logic signed [XW-1:0] sp;
      logic                 oor;
   } div_side_type;

   // carried alongside the root
   typedef struct packed {
      logic signed [31:0]   x30;
      logic signed [XW-1:0] cp;
      logic signed [XW-1:0] sp;
      logic                 oor;
   } root_side_type;

   // arctangent table in Q0.32 turns
   function automatic logic [31:0] atan_turn(input logic [3:0] k);
      logic [31:0] v;
      unique case (k)
         4'd0:  v = 32'h20000000;
         4'd1:  v = 32'h12E4051E;
         4'd2:  v = 32'h09FB385B;
         4'd3:  v = 32'h051111D4;
         4'd4:  v = 32'h028B0D43;
         4'd5:  v = 32'h0145D7E1;
         4'd6:  v = 32'h00A2F61E;
         4'd7:  v = 32'h00517C55;
         4'd8:  v = 32'h0028BE53;
         4'd9:  v = 32'h00145F2F;
         4'd10: v = 32'h000A2F98;
         4'd11: v = 32'h000517CC;
         4'd12: v = 32'h00028BE6;
         4'd13: v = 32'h000145F3;
         4'd14: v = 32'h0000A2FA;
         4'd15: v = 32'h0000517D;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

// ===== design/fcd_queue.sv =====
// fcd_queue: short item queue between front and back
// depends on fcd_pkg
`timescale 1ns / 1ps
module fcd_queue import fcd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head_item,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

   assign head_item    = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== design/fcd_front.sv =====
// fcd_front: accepts request items and classifies them against the ray count
// depends on fcd_pkg
`timescale 1ns / 1ps
module fcd_front import fcd_pkg::*; (
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [INDEX_W-1:0] req_ray_index,
   input  logic [COUNT_W-1:0] eff_count,
   input  queue_status_type   q_status,
   output logic               push,
   output item_type           push_item
);

   // take an item whenever the queue has room
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // out of range when the index is not below the effective count
   assign push_item.ray_index = req_ray_index;
   assign push_item.oor       = ({1'b0, req_ray_index} >= eff_count);

endmodule

// ===== design/fcd_cordic.sv =====
// fcd_cordic: pipelined 16 step sine/cosine of a Q0.32 turn phase, results in Q2.30
// depends on fcd_pkg (arctangent table, gain)
`timescale 1ns / 1ps
module fcd_cordic import fcd_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [31:0]          ph_i,
   output logic signed [XW-1:0] cos_o,
   output logic signed [XW-1:0] sin_o
);

   logic signed [XW-1:0] x_ff [CORDIC_STAGES];
   logic signed [XW-1:0] y_ff [CORDIC_STAGES];
   logic signed [ZW-1:0] z_ff [CORDIC_STAGES];
   logic                 f_ff [CORDIC_STAGES];
   logic signed [XW-1:0] x_in [CORDIC_STAGES];
   logic signed [XW-1:0] y_in [CORDIC_STAGES];
   logic signed [ZW-1:0] z_in [CORDIC_STAGES];
   logic                 f_in [CORDIC_STAGES];
   logic                 flip0;
   logic [31:0]          ph_adj;

   // phases in the second and third quarter are turned by half a turn
   assign flip0  = ph_i[31] ^ ph_i[30];
   assign ph_adj = flip0 ? {~ph_i[31], ph_i[30:0]} : ph_i;

   // one rotation per stage
   always_comb begin
      logic signed [XW-1:0] xp, yp;
      logic signed [ZW-1:0] zp, at;
      for (int k = 0; k < CORDIC_STAGES; k++) begin
         if (k == 0) begin
            xp = XW'(CORDIC_GAIN);
            yp = '0;
            zp = ZW'(signed'(ph_adj));
            f_in[k] = flip0;
         end else begin
            xp = x_ff[k-1];
            yp = y_ff[k-1];
            zp = z_ff[k-1];
            f_in[k] = f_ff[k-1];
         end
         at = {{(ZW-32){1'b0}}, atan_turn(4'(k))};
         if (zp >= 0) begin
            x_in[k] = xp - (yp >>> k);
            y_in[k] = yp + (xp >>> k);
            z_in[k] = zp - at;
         end else begin
            x_in[k] = xp + (yp >>> k);
            y_in[k] = yp - (xp >>> k);
            z_in[k] = zp + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         f_ff <= f_in;
      end
   end

   // undo the half turn
   assign cos_o = f_ff[CORDIC_STAGES-1] ? -x_ff[CORDIC_STAGES-1] : x_ff[CORDIC_STAGES-1];
   assign sin_o = f_ff[CORDIC_STAGES-1] ? -y_ff[CORDIC_STAGES-1] : y_ff[CORDIC_STAGES-1];

endmodule

// ===== design/fcd_divider.sv =====
// fcd_divider: pipelined restoring divider, one quotient bit per stage
// depends on fcd_pkg; quotient must fit in 32 bits
`timescale 1ns / 1ps
module fcd_divider import fcd_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic [DIVIDEND_W-1:0] dividend_i,
   input  logic [COUNT_W-1:0]    divisor_i,
   output logic [31:0]           quotient_o
);

   logic [COUNT_W-1:0] rem_ff [DIV_STAGES];
   logic [31:0]        lo_ff  [DIV_STAGES];
   logic [31:0]        q_ff   [DIV_STAGES];
   logic [COUNT_W-1:0] rem_in [DIV_STAGES];
   logic [31:0]        lo_in  [DIV_STAGES];
   logic [31:0]        q_in   [DIV_STAGES];

   // shift in one dividend bit, subtract when it fits
   always_comb begin
      logic [COUNT_W-1:0] rp;
      logic [31:0]        lp, qp;
      logic [COUNT_W:0]   t;
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            rp = dividend_i[DIVIDEND_W-1:32];
            lp = dividend_i[31:0];
            qp = '0;
         end else begin
            rp = rem_ff[k-1];
            lp = lo_ff[k-1];
            qp = q_ff[k-1];
         end
         t = {rp, lp[31]};
         if (t >= {1'b0, divisor_i}) begin
            rem_in[k] = COUNT_W'(t - {1'b0, divisor_i});
            q_in[k]   = {qp[30:0], 1'b1};
         end else begin
            rem_in[k] = COUNT_W'(t);
            q_in[k]   = {qp[30:0], 1'b0};
         end
         lo_in[k] = {lp[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         lo_ff  <= lo_in;
         q_ff   <= q_in;
      end
   end

   assign quotient_o = q_ff[DIV_STAGES-1];

endmodule

// ===== design/fcd_sqrt.sv =====
// fcd_sqrt: pipelined digit by digit integer square root, one result bit per stage
// depends on fcd_pkg
`timescale 1ns / 1ps
module fcd_sqrt import fcd_pkg::*; (
   input  logic            clock,
   input  logic            en,
   input  logic [SQ_W-1:0] radicand_i,
   output logic [30:0]     root_o
);

   logic [SQ_W-1:0]   n_ff   [SQRT_STAGES];
   logic [ROOT_W-1:0] res_ff [SQRT_STAGES];
   logic [SQ_W-1:0]   n_in   [SQRT_STAGES];
   logic [ROOT_W-1:0] res_in [SQRT_STAGES];

   // trial subtract of res + bit, bit walks down two places a stage
   always_comb begin
      logic [SQ_W-1:0]   np;
      logic [ROOT_W-1:0] rp, bitv, sum;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (k == 0) begin
            np = radicand_i;
            rp = '0;
         end else begin
            np = n_ff[k-1];
            rp = res_ff[k-1];
         end
         bitv = ROOT_W'(1) << (62 - 2 * k);
         sum  = rp + bitv;
         if ({{(ROOT_W-SQ_W){1'b0}}, np} >= sum) begin
            n_in[k]   = SQ_W'({{(ROOT_W-SQ_W){1'b0}}, np} - sum);
            res_in[k] = (rp >> 1) + bitv;
         end else begin
            n_in[k]   = np;
            res_in[k] = rp >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff   <= n_in;
         res_ff <= res_in;
      end
   end

   assign root_o = res_ff[SQRT_STAGES-1][30:0];

endmodule

// ===== design/fcd_back.sv =====
// fcd_back: pipeline that turns a classified item into a Q1.15 direction
// depends on fcd_pkg, fcd_cordic, fcd_divider, fcd_sqrt
`timescale 1ns / 1ps
module fcd_back import fcd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  item_type                head_item,
   input  queue_status_type        q_status,
   output logic                    pop,
   input  logic [CAP_W-1:0]        cap_half_angle,
   input  logic [COUNT_W-1:0]      eff_count,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic signed [DIR_W-1:0] rsp_dir_x,
   output logic signed [DIR_W-1:0] rsp_dir_y,
   output logic signed [DIR_W-1:0] rsp_dir_z,
   output logic                    rsp_index_out_of_range
);

   localparam int DEPTH = 2 + CORDIC_STAGES + 1 + DIV_STAGES + 1 + SQRT_STAGES + 1 + 1;

   // Q2.30 to Q1.15 with rounding and saturation
   function automatic logic [DIR_W-1:0] to_q15(input logic signed [33:0] v);
      logic signed [34:0] s;
      logic signed [19:0] r;
      s = 35'(v) + 35'sd16384;
      r = 20'(s >>> 15);
      if (r > 20'sd32767) return 16'h7FFF;
      else if (r < -20'sd32768) return 16'h8000;
      else return r[15:0];
   endfunction

   logic             en;
   logic [DEPTH-1:0] vld_ff;

   // whole pipeline advances unless a finished item is held
   assign en  = !(vld_ff[DEPTH-1] && rsp_stall);
   assign pop = en && !q_status.empty;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[DEPTH-2:0], pop};
   end
   assign rsp_valid = vld_ff[DEPTH-1];

   // stage 1: cap angle scaling products and spiral phase
   item_type    s1_item_ff, s2_item_ff;
   logic [31:0] s1_capmul_ff, s1_ph_ff, s2_capph_ff, s2_ph_ff;
   logic [42:0] s1_frac_ff;
   logic [20:0] frac_num;
   logic [42:0] ph_prod;

   assign frac_num = 21'(cap_half_angle) * 21'(CAP_REM) + 21'(CAP_OFFSET);
   assign ph_prod  = 43'(head_item.ray_index) * 43'(GOLDEN_STEP);

   always_ff @(posedge clock) begin
      if (en) begin
         s1_item_ff   <= head_item;
         s1_capmul_ff <= 32'(cap_half_angle) * 32'(CAP_SCALE);
         s1_frac_ff   <= 43'(frac_num) * 43'(CAP_RECIP);
         s1_ph_ff     <= ph_prod[31:0];
      end
   end

   // stage 2: cap phase in turns
   always_ff @(posedge clock) begin
      if (en) begin
         s2_item_ff  <= s1_item_ff;
         s2_capph_ff <= s1_capmul_ff + 32'(s1_frac_ff[42:CAP_RECIP_SHIFT]);
         s2_ph_ff    <= s1_ph_ff;
      end
   end

   // both rotations side by side
   logic signed [XW-1:0] cap_cos, ray_cos, ray_sin;
   item_type             side1_ff [CORDIC_STAGES];

   fcd_cordic u_cap_cordic (
      .clock (clock),
      .en    (en),
      .ph_i  (s2_capph_ff),
      .cos_o (cap_cos),
      .sin_o ()
   );

   fcd_cordic u_ray_cordic (
      .clock (clock),
      .en    (en),
      .ph_i  (s2_ph_ff),
      .cos_o (ray_cos),
      .sin_o (ray_sin)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff[0] <= s2_item_ff;
         for (int k = 1; k < CORDIC_STAGES; k++) side1_ff[k] <= side1_ff[k-1];
      end
   end

   // dividend (i+1)*range + n/2
   item_type                d_item;
   logic signed [33:0]      range_s;
   logic [31:0]             range_u;
   logic [DIVIDEND_W-1:0]   d_ff;
   div_side_type            d_side_ff;

   assign d_item  = side1_ff[CORDIC_STAGES-1];
   assign range_s = 34'sd1073741824 - 34'(cap_cos);
   assign range_u = range_s[33] ? 32'd0 : range_s[31:0];

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= DIVIDEND_W'({1'b0, d_item.ray_index} + COUNT_W'(1)) * DIVIDEND_W'(range_u)
                 + DIVIDEND_W'(eff_count >> 1);
         d_side_ff.cp  <= ray_cos;
         d_side_ff.sp  <= ray_sin;
         d_side_ff.oor <= d_item.oor;
      end
   end

   // division by the ray count
   logic [31:0]  quot;
   div_side_type side2_ff [DIV_STAGES];

   fcd_divider u_divider (
      .clock      (clock),
      .en         (en),
      .dividend_i (d_ff),
      .divisor_i  (eff_count),
      .quotient_o (quot)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff[0] <= d_side_ff;
         for (int k = 1; k < DIV_STAGES; k++) side2_ff[k] <= side2_ff[k-1];
      end
   end

   // x30 with lower clamp, then 1 - x^2
   logic signed [33:0] x_s, x_c;
   logic signed [31:0] x30;
   logic signed [63:0] xx;
   logic [SQ_W-1:0]    sq_ff;
   root_side_type      x_side_ff;

   assign x_s = 34'sd1073741824 - $signed({2'b00, quot});
   assign x_c = (x_s < -34'sd1073741824) ? -34'sd1073741824 : x_s;
   assign x30 = 32'(x_c);
   assign xx  = x30 * x30;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff         <= SQ_W'(64'sh1000_0000_0000_0000 - xx);
         x_side_ff.x30 <= x30;
         x_side_ff.cp  <= side2_ff[DIV_STAGES-1].cp;
         x_side_ff.sp  <= side2_ff[DIV_STAGES-1].sp;
         x_side_ff.oor <= side2_ff[DIV_STAGES-1].oor;
      end
   end

   // radius
   logic [30:0]   root;
   root_side_type side3_ff [SQRT_STAGES];

   fcd_sqrt u_sqrt (
      .clock      (clock),
      .en         (en),
      .radicand_i (sq_ff),
      .root_o     (root)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         side3_ff[0] <= x_side_ff;
         for (int k = 1; k < SQRT_STAGES; k++) side3_ff[k] <= side3_ff[k-1];
      end
   end

   // radius times cosine and sine
   root_side_type      p_side;
   logic signed [63:0] py_in, pz_in, py_ff, pz_ff;
   logic signed [31:0] px_ff;
   logic               p_oor_ff;

   assign p_side = side3_ff[SQRT_STAGES-1];
   assign py_in  = $signed({1'b0, root}) * p_side.cp;
   assign pz_in  = $signed({1'b0, root}) * p_side.sp;

   always_ff @(posedge clock) begin
      if (en) begin
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         px_ff    <= p_side.x30;
         p_oor_ff <= p_side.oor;
      end
   end

   // output register, zeros for an index out of range
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_index_out_of_range <= p_oor_ff;
         if (p_oor_ff) begin
            rsp_dir_x <= '0;
            rsp_dir_y <= '0;
            rsp_dir_z <= '0;
         end else begin
            rsp_dir_x <= to_q15(34'(px_ff));
            rsp_dir_y <= to_q15(34'(py_ff >>> 30));
            rsp_dir_z <= to_q15(34'(pz_ff >>> 30));
         end
      end
   end

endmodule

// ===== design/fibonacci_cap_direction_unit.sv =====
// fibonacci_cap_direction_unit: top level with register port, front, queue and back
// depends on fcd_pkg, fcd_front, fcd_queue, fcd_back
`timescale 1ns / 1ps
// Gives the unit direction of ray req_ray_index on a golden-angle spiral over a spherical
// cap around +x, as Q1.15 x, y, z. One item is taken per cycle while the four-entry input
// queue has room. Each item passes through the two 16-stage cordic pipelines side by side,
// the 32-stage divider by the ray count and the 32-stage square root. A held result freezes
// the back pipeline while the queue keeps taking items until it is full. Registers at
// byte 0 (ray_count) and 4 (cap_half_angle, Q8.8 degrees) are to be written over the
// APB-style port only while no item is in flight; the unit itself does not enforce this.
module fibonacci_cap_direction_unit import fcd_pkg::*; #(
   parameter int MAX_RAYS = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [INDEX_W-1:0]      req_ray_index,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [DIR_W-1:0] rsp_dir_x,
   output logic signed [DIR_W-1:0] rsp_dir_y,
   output logic signed [DIR_W-1:0] rsp_dir_z,
   output logic                    rsp_index_out_of_range,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_W-1:0]       paddr,
   input  logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]       prdata,
   output logic                    pready
);

   logic [COUNT_W-1:0] ray_count_ff, eff_count;
   logic [CAP_W-1:0]   cap_angle_ff;
   logic               wr_en;

   // register writes
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_count_ff <= RAY_COUNT_RESET;
         cap_angle_ff <= CAP_ANGLE_RESET;
      end else if (wr_en) begin
         unique case (paddr[2])
            REG_RAY_COUNT: ray_count_ff <= pwdata[COUNT_W-1:0];
            REG_CAP_ANGLE: cap_angle_ff <= pwdata[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   // readback
   always_comb begin
      unique case (paddr[2])
         REG_RAY_COUNT: prdata = DATA_W'(ray_count_ff);
         REG_CAP_ANGLE: prdata = DATA_W'(cap_angle_ff);
         default:       prdata = '0;
      endcase
   end

   // count limited by the largest supported ray count
   assign eff_count = (32'(ray_count_ff) > MAX_RAYS) ? COUNT_W'(MAX_RAYS) : ray_count_ff;

   queue_status_type q_status;
   item_type         push_item, head_item;
   logic             push, pop;

   fcd_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ray_index (req_ray_index),
      .eff_count     (eff_count),
      .q_status      (q_status),
      .push          (push),
      .push_item     (push_item)
   );

   fcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   fcd_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .head_item              (head_item),
      .q_status               (q_status),
      .pop                    (pop),
      .cap_half_angle         (cap_angle_ff),
      .eff_count              (eff_count),
      .rsp_stall              (rsp_stall),
      .rsp_valid              (rsp_valid),
      .rsp_dir_x              (rsp_dir_x),
      .rsp_dir_y              (rsp_dir_y),
      .rsp_dir_z              (rsp_dir_z),
      .rsp_index_out_of_range (rsp_index_out_of_range)
   );

endmodule

// ===== design/fcd_checker.sv =====
// fcd_checker: port level assertions for fibonacci_cap_direction_unit, bound to the top
// depends on fcd_pkg and fibonacci_cap_direction_unit
`timescale 1ns / 1ps
module fcd_checker import fcd_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [DIR_W-1:0] rsp_dir_x,
   input logic signed [DIR_W-1:0] rsp_dir_y,
   input logic signed [DIR_W-1:0] rsp_dir_z,
   input logic                    rsp_index_out_of_range
);

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dir_x) && $stable(rsp_dir_y)
         && $stable(rsp_dir_z) && $stable(rsp_index_out_of_range))
      else $error("held result changed");

   // an out of range item carries a zero direction
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_out_of_range |->
         rsp_dir_x == 16'sd0 && rsp_dir_y == 16'sd0 && rsp_dir_z == 16'sd0)
      else $error("out of range item with nonzero direction");

endmodule

bind fibonacci_cap_direction_unit fcd_checker u_fcd_checker (.*);
